// ----- sv/cfsp_pkg.sv -----
package cfsp_pkg;
  localparam logic [31:0] MagicWord = 32'hCAFEBABE;
  localparam logic [5:0] PhMagic = 6'd0, PhMinor = 6'd1, PhMajor = 6'd2, PhPoolCnt = 6'd3,
    PhTag = 6'd4, PhPval = 6'd5, PhPwide2 = 6'd6, PhStr = 6'd7, PhAccess = 6'd8,
    PhThis = 6'd9, PhSuper = 6'd10, PhIfCnt = 6'd11, PhIface = 6'd12, PhBlock = 6'd16,
    PhDone = 6'd40;
  localparam logic [7:0] TagUtf8 = 8'd1, TagLong = 8'd5, TagDouble = 8'd6, TagClass = 8'd7,
    TagString = 8'd8, TagMhandle = 8'd15, TagMtype = 8'd16;
  localparam logic [2:0] KCount = 3'd0, KScalar = 3'd1, KTag = 3'd2, KPval = 3'd3,
    KStr = 3'd4, KAName = 3'd5, KALen = 3'd6, KAByte = 3'd7;
  localparam logic [2:0] StOk = 3'd0, StMagic = 3'd1, StTag = 3'd2, StEarly = 3'd3,
    StTrail = 3'd4;
  localparam logic [2:0] SecHeader = 3'd0, SecPool = 3'd1, SecClass = 3'd2, SecIface = 3'd3,
    SecFields = 3'd4, SecMethods = 3'd5, SecAttrs = 3'd6;

  typedef struct packed {
    logic [2:0]  section;
    logic [2:0]  kind;
    logic [15:0] entry;
    logic [15:0] attr;
    logic [31:0] value;
    logic [2:0]  status;
    logic        done;
  } result_t;

  function automatic logic [5:0] block_base(input logic [2:0] sec);
    block_base = PhBlock + {sec - SecFields, 3'b000};
  endfunction

  function automatic logic [2:0] section_of(input logic [5:0] ph);
    if (ph < PhPoolCnt) section_of = SecHeader;
    else if (ph <= PhStr) section_of = SecPool;
    else if (ph <= PhSuper) section_of = SecClass;
    else if (ph <= PhIface) section_of = SecIface;
    else if (ph >= PhDone) section_of = SecAttrs;
    else section_of = SecFields + {1'b0, ph[4:3] - 2'd2};
  endfunction

  function automatic logic tag_ok(input logic [7:0] t);
    tag_ok = (t == 8'd1) || (t >= 8'd3 && t <= 8'd12) || t == 8'd15 || t == 8'd16 ||
      t == 8'd18;
  endfunction
endpackage

// ----- sv/class_file_stream_parser.sv -----
// A result is written to the output register when its byte is accepted.
// One byte per cycle unless a held result stalls; output refills in the cycle it is taken.
// Reset: asynchronous active low; the parser waits for the magic number, output is empty.
// A byte flagged as last also returns the parser to its reset state.
module class_file_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  section_o,
  output logic [2:0]  item_kind_o,
  output logic [15:0] entry_index_o,
  output logic [15:0] attr_index_o,
  output logic [31:0] field_value_o,
  output logic [2:0]  status_o,
  output logic        class_done_o
);
  logic [5:0] phase_q, phase_d;
  logic [2:0] nbytes_q, nbytes_d;
  logic [31:0] asm_q, asm_d, pay_q, pay_d;
  logic [15:0] left_q, left_d, entry_q, entry_d, aleft_q, aleft_d, acnt_q, acnt_d;
  logic [7:0] tag_q, tag_d;
  logic halted_q, halted_d;
  logic ovalid_q;
  cfsp_pkg::result_t res_q, r;
  logic emit;
  logic accept;

  assign in_stall_o = ovalid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    logic [2:0] need, sec, off;
    logic [31:0] v, pl;
    logic [16:0] nxt;
    logic [15:0] sl, al;
    phase_d = phase_q; nbytes_d = nbytes_q; asm_d = asm_q; pay_d = pay_q;
    left_d = left_q; entry_d = entry_q; aleft_d = aleft_q; acnt_d = acnt_q;
    tag_d = tag_q; halted_d = halted_q;
    r = '0; emit = 1'b0;
    need = 3'd2; v = '0; nxt = '0; pl = '0; sl = '0; al = '0;
    off = phase_q[2:0];
    sec = cfsp_pkg::section_of(phase_q);
    if (phase_q == cfsp_pkg::PhMagic || phase_q == cfsp_pkg::PhPwide2) need = 3'd4;
    else if (phase_q == cfsp_pkg::PhTag || phase_q == cfsp_pkg::PhStr) need = 3'd1;
    else if (phase_q == cfsp_pkg::PhPval) begin
      if (tag_q == cfsp_pkg::TagUtf8 || tag_q == cfsp_pkg::TagClass ||
          tag_q == cfsp_pkg::TagString || tag_q == cfsp_pkg::TagMtype) need = 3'd2;
      else if (tag_q == cfsp_pkg::TagMhandle) need = 3'd3;
      else need = 3'd4;
    end else if (phase_q >= cfsp_pkg::PhBlock && phase_q < cfsp_pkg::PhDone) begin
      if (off == 3'd7) need = 3'd1;
      else if (off == 3'd6) need = 3'd4;
    end
    if (halted_q) begin
      emit = 1'b0;
    end else if (phase_q == cfsp_pkg::PhDone) begin
      r.section = cfsp_pkg::SecAttrs; r.status = cfsp_pkg::StTrail; halted_d = 1'b1;
      emit = 1'b1;
    end else begin
      v = {asm_q[23:0], in_byte_i};
      asm_d = v;
      nbytes_d = nbytes_q + 3'd1;
      if (nbytes_d >= need) begin
        asm_d = '0; nbytes_d = '0; emit = 1'b1;
        r.section = sec; r.kind = cfsp_pkg::KScalar; r.value = v;
        case (phase_q)
          cfsp_pkg::PhMagic: begin
            if (v != cfsp_pkg::MagicWord) begin
              r.status = cfsp_pkg::StMagic; halted_d = 1'b1;
            end else phase_d = cfsp_pkg::PhMinor;
          end
          cfsp_pkg::PhMinor: begin r.entry = 16'd1; phase_d = cfsp_pkg::PhMajor; end
          cfsp_pkg::PhMajor: begin r.entry = 16'd2; phase_d = cfsp_pkg::PhPoolCnt; end
          cfsp_pkg::PhPoolCnt: begin
            r.kind = cfsp_pkg::KCount;
            left_d = v[15:0]; entry_d = '0;
            if (v[15:0] <= 16'd1) phase_d = cfsp_pkg::PhAccess;
            else begin entry_d = 16'd1; phase_d = cfsp_pkg::PhTag; end
          end
          cfsp_pkg::PhTag: begin
            r.kind = cfsp_pkg::KTag; r.entry = entry_q;
            tag_d = v[7:0];
            if (!cfsp_pkg::tag_ok(v[7:0])) begin
              r.status = cfsp_pkg::StTag; halted_d = 1'b1;
            end else phase_d = cfsp_pkg::PhPval;
          end
          cfsp_pkg::PhPval, cfsp_pkg::PhPwide2, cfsp_pkg::PhStr: begin
            r.entry = entry_q;
            nxt = {1'b0, entry_q} + 17'd1;
            if (phase_q == cfsp_pkg::PhPval) begin
              r.kind = cfsp_pkg::KPval;
              if (tag_q == cfsp_pkg::TagUtf8) begin
                pay_d = v; acnt_d = '0;
                if (v != '0) begin phase_d = cfsp_pkg::PhStr; nxt = '0; end
              end else if (tag_q == cfsp_pkg::TagLong || tag_q == cfsp_pkg::TagDouble) begin
                phase_d = cfsp_pkg::PhPwide2; nxt = '0;
              end
            end else if (phase_q == cfsp_pkg::PhPwide2) begin
              r.kind = cfsp_pkg::KPval; r.entry = entry_q + 16'd1;
              nxt = {1'b0, entry_q} + 17'd2;
            end else begin
              r.kind = cfsp_pkg::KStr; r.attr = acnt_q;
              acnt_d = acnt_q + 16'd1;
              pay_d = pay_q - 32'd1;
              if (pay_d == '0) acnt_d = '0;
              else nxt = '0;
            end
            // advance pool slot when this entry is finished
            if (nxt != '0) begin
              if (nxt >= {1'b0, left_q}) phase_d = cfsp_pkg::PhAccess;
              else begin entry_d = nxt[15:0]; phase_d = cfsp_pkg::PhTag; end
            end
          end
          cfsp_pkg::PhAccess: phase_d = cfsp_pkg::PhThis;
          cfsp_pkg::PhThis: begin r.entry = 16'd1; phase_d = cfsp_pkg::PhSuper; end
          cfsp_pkg::PhSuper: begin r.entry = 16'd2; phase_d = cfsp_pkg::PhIfCnt; end
          cfsp_pkg::PhIfCnt: begin
            r.kind = cfsp_pkg::KCount;
            left_d = v[15:0]; entry_d = '0;
            phase_d = (v[15:0] != '0) ? cfsp_pkg::PhIface :
              cfsp_pkg::block_base(cfsp_pkg::SecFields);
          end
          cfsp_pkg::PhIface: begin
            r.entry = entry_q;
            entry_d = entry_q + 16'd1;
            left_d = left_q - 16'd1;
            if (left_d == '0) phase_d = cfsp_pkg::block_base(cfsp_pkg::SecFields);
          end
          default: begin
            r.entry = entry_q;
            if (off >= 3'd5) r.attr = acnt_q;
            al = 16'hFFFF; // marker: no attribute finished
            case (off)
              3'd0: begin
                r.kind = cfsp_pkg::KCount; r.entry = '0;
                if (sec == cfsp_pkg::SecAttrs) begin
                  entry_d = '0; aleft_d = v[15:0]; acnt_d = '0; al = v[15:0];
                end else begin
                  left_d = v[15:0]; entry_d = '0;
                  if (v[15:0] == '0)
                    phase_d = cfsp_pkg::block_base((sec == cfsp_pkg::SecFields) ?
                      cfsp_pkg::SecMethods : cfsp_pkg::SecAttrs);
                  else phase_d = cfsp_pkg::block_base(sec) + 6'd1;
                end
              end
              3'd1, 3'd2, 3'd3: phase_d = phase_q + 6'd1;
              3'd4: begin
                r.kind = cfsp_pkg::KCount;
                aleft_d = v[15:0]; acnt_d = '0; al = v[15:0];
              end
              3'd5: begin r.kind = cfsp_pkg::KAName; phase_d = phase_q + 6'd1; end
              3'd6: begin
                r.kind = cfsp_pkg::KALen; pay_d = v;
                if (v == '0) begin
                  acnt_d = acnt_q + 16'd1; aleft_d = aleft_q - 16'd1; al = aleft_d;
                end else phase_d = phase_q + 6'd1;
              end
              default: begin
                r.kind = cfsp_pkg::KAByte;
                pl = pay_q - 32'd1; pay_d = pl;
                if (pl == '0) begin
                  acnt_d = acnt_q + 16'd1; aleft_d = aleft_q - 16'd1; al = aleft_d;
                end
              end
            endcase
            // start next attribute or close the owner
            if (al != 16'hFFFF || (off == 3'd0 && sec == cfsp_pkg::SecAttrs) ||
                off == 3'd4 || (off == 3'd6 && v == '0) || (off == 3'd7 && pl == '0)) begin
              if (aleft_d != '0) phase_d = cfsp_pkg::block_base(sec) + 6'd5;
              else if (sec == cfsp_pkg::SecAttrs) begin
                phase_d = cfsp_pkg::PhDone; r.done = 1'b1;
              end else begin
                entry_d = entry_q + 16'd1;
                sl = left_q - 16'd1; left_d = sl;
                if (sl != '0) phase_d = cfsp_pkg::block_base(sec) + 6'd1;
                else phase_d = cfsp_pkg::block_base((sec == cfsp_pkg::SecFields) ?
                  cfsp_pkg::SecMethods : cfsp_pkg::SecAttrs);
              end
            end
          end
        endcase
      end
    end
    if (last_byte_i) begin
      if (!halted_q) begin
        if (!emit || (r.status == cfsp_pkg::StOk && !r.done)) begin
          r.section = cfsp_pkg::section_of(phase_d);
          r.kind = cfsp_pkg::KCount; r.entry = entry_d; r.attr = acnt_d;
          r.value = '0; r.status = cfsp_pkg::StEarly; r.done = 1'b0; emit = 1'b1;
        end
      end
      phase_d = cfsp_pkg::PhMagic; nbytes_d = '0; asm_d = '0; pay_d = '0;
      left_d = '0; entry_d = '0; aleft_d = '0; acnt_d = '0; tag_d = '0; halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfsp_pkg::PhMagic; nbytes_q <= '0; asm_q <= '0; pay_q <= '0;
      left_q <= '0; entry_q <= '0; aleft_q <= '0; acnt_q <= '0; tag_q <= '0;
      halted_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d; nbytes_q <= nbytes_d; asm_q <= asm_d; pay_q <= pay_d;
        left_q <= left_d; entry_q <= entry_d; aleft_q <= aleft_d; acnt_q <= acnt_d;
        tag_q <= tag_d; halted_q <= halted_d;
      end
      if (accept) ovalid_q <= emit;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) res_q <= r;
  end

  assign out_valid_o = ovalid_q;
  assign section_o = res_q.section;
  assign item_kind_o = res_q.kind;
  assign entry_index_o = res_q.entry;
  assign attr_index_o = res_q.attr;
  assign field_value_o = res_q.value;
  assign status_o = res_q.status;
  assign class_done_o = res_q.done;
endmodule
